@@ rtl/integer_to_ascii_formatter_assert.svh @@
`ifndef INTEGER_TO_ASCII_FORMATTER_ASSERT_SVH
`define INTEGER_TO_ASCII_FORMATTER_ASSERT_SVH

// checked only out of reset
`define ITOA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked through reset as well
`define ITOA_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/itoa_pkg.sv @@
package itoa_pkg;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [6:0] ch;
    logic       last;
  } out_item_t;

  localparam logic [2:0] OP_S16   = 3'd0;
  localparam logic [2:0] OP_U16   = 3'd1;
  localparam logic [2:0] OP_S32   = 3'd2;
  localparam logic [2:0] OP_U32   = 3'd3;
  localparam logic [2:0] OP_HEX16 = 3'd4;

  localparam logic [6:0] CH_ZERO  = 7'h30;
  localparam logic [6:0] CH_MINUS = 7'h2D;
  localparam logic [6:0] CH_A     = 7'h41;

  localparam logic [3:0] K_START16 = 4'd5;
  localparam logic [3:0] K_LAST    = 4'd9;
  localparam logic [3:0] NIB_TEN   = 4'd10;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SIGN,
    ST_DIV,
    ST_PUT,
    ST_HEX
  } state_t;

  typedef struct packed {
    logic load;
    logic sub;
    logic advance;
    logic push_sign;
    logic push_digit;
    logic push_hex;
  } cmd_t;

  typedef struct packed {
    logic slot_free;
    logic ge;
    logic emit_need;
    logic k_last;
    logic hex_last;
    logic fmt_bad;
    logic fmt_hex;
    logic fmt_neg;
  } sts_t;

  function automatic logic [31:0] pow10(input logic [3:0] k);
    logic [31:0] p;
    unique case (k)
      4'd0:    p = 32'd1000000000;
      4'd1:    p = 32'd100000000;
      4'd2:    p = 32'd10000000;
      4'd3:    p = 32'd1000000;
      4'd4:    p = 32'd100000;
      4'd5:    p = 32'd10000;
      4'd6:    p = 32'd1000;
      4'd7:    p = 32'd100;
      4'd8:    p = 32'd10;
      default: p = 32'd1;
    endcase
    return p;
  endfunction

endpackage

@@ rtl/itoa_dp.sv @@
module itoa_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  itoa_pkg::in_item_t   in_payload,
  input  logic                 out_stall,
  output logic                 out_valid,
  output itoa_pkg::out_item_t  out_payload,
  input  itoa_pkg::cmd_t       cmd,
  output itoa_pkg::sts_t       sts
);

  logic [31:0]         mag_r, mag_nxt;
  logic [3:0]          k_r, k_nxt;
  logic [3:0]          dig_r, dig_nxt;
  logic                started_r, started_nxt;
  logic [1:0]          hcnt_r, hcnt_nxt;
  logic                out_valid_r, out_valid_nxt;
  itoa_pkg::out_item_t out_r, out_nxt;

  logic [31:0] pow;
  logic [31:0] load_mag;
  logic [16:0] neg16;
  logic [3:0]  nib;
  logic [6:0]  hex_ch;

  assign pow   = itoa_pkg::pow10(k_r);
  assign neg16 = 17'h10000 - {1'b0, in_payload.value[15:0]};
  assign nib   = mag_r[15:12];
  assign hex_ch = (nib < itoa_pkg::NIB_TEN) ? (itoa_pkg::CH_ZERO + {3'b000, nib})
                : (itoa_pkg::CH_A + {3'b000, nib - itoa_pkg::NIB_TEN});

  always_comb begin
    unique case (in_payload.op)
      itoa_pkg::OP_S16:
        load_mag = in_payload.value[15] ? {15'b0, neg16} : {16'b0, in_payload.value[15:0]};
      itoa_pkg::OP_S32:
        load_mag = in_payload.value[31] ? (32'd0 - in_payload.value) : in_payload.value;
      itoa_pkg::OP_U32:
        load_mag = in_payload.value;
      default:
        load_mag = {16'b0, in_payload.value[15:0]};
    endcase
  end

  always_comb begin
    sts.slot_free = !out_valid_r || !out_stall;
    sts.ge        = mag_r >= pow;
    sts.k_last    = k_r == itoa_pkg::K_LAST;
    sts.emit_need = started_r || (dig_r != 4'd0) || (k_r == itoa_pkg::K_LAST);
    sts.hex_last  = hcnt_r == 2'd3;
    sts.fmt_bad   = in_payload.op > itoa_pkg::OP_HEX16;
    sts.fmt_hex   = in_payload.op == itoa_pkg::OP_HEX16;
    sts.fmt_neg   = ((in_payload.op == itoa_pkg::OP_S16) && in_payload.value[15]) ||
                    ((in_payload.op == itoa_pkg::OP_S32) && in_payload.value[31]);
  end

  always_comb begin
    mag_nxt       = mag_r;
    k_nxt         = k_r;
    dig_nxt       = dig_r;
    started_nxt   = started_r;
    hcnt_nxt      = hcnt_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.load) begin
      mag_nxt     = load_mag;
      k_nxt       = ((in_payload.op == itoa_pkg::OP_S16) ||
                     (in_payload.op == itoa_pkg::OP_U16)) ? itoa_pkg::K_START16 : 4'd0;
      dig_nxt     = 4'd0;
      started_nxt = 1'b0;
      hcnt_nxt    = 2'd0;
    end
    if (cmd.sub) begin
      mag_nxt = mag_r - pow;
      dig_nxt = dig_r + 4'd1;
    end
    if (cmd.advance || cmd.push_digit) begin
      k_nxt   = k_r + 4'd1;
      dig_nxt = 4'd0;
    end
    if (cmd.push_sign) begin
      out_nxt.ch    = itoa_pkg::CH_MINUS;
      out_nxt.last  = 1'b0;
      out_valid_nxt = 1'b1;
    end
    if (cmd.push_digit) begin
      out_nxt.ch    = itoa_pkg::CH_ZERO + {3'b000, dig_r};
      out_nxt.last  = sts.k_last;
      out_valid_nxt = 1'b1;
      started_nxt   = 1'b1;
    end
    if (cmd.push_hex) begin
      out_nxt.ch    = hex_ch;
      out_nxt.last  = sts.hex_last;
      out_valid_nxt = 1'b1;
      mag_nxt       = {mag_r[27:0], 4'b0000};
      hcnt_nxt      = hcnt_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r     <= mag_nxt;
    k_r       <= k_nxt;
    dig_r     <= dig_nxt;
    started_r <= started_nxt;
    hcnt_r    <= hcnt_nxt;
    out_r     <= out_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_payload = out_r;

endmodule

@@ rtl/itoa_ctrl.sv @@
module itoa_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  itoa_pkg::sts_t  sts,
  output itoa_pkg::cmd_t  cmd
);

  itoa_pkg::state_t state_r, state_nxt;
  logic             accept;

  assign in_stall = state_r != itoa_pkg::ST_IDLE;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      itoa_pkg::ST_IDLE: begin
        if (accept) begin
          priority if (sts.fmt_bad) state_nxt = itoa_pkg::ST_IDLE;
          else if (sts.fmt_hex)     state_nxt = itoa_pkg::ST_HEX;
          else if (sts.fmt_neg)     state_nxt = itoa_pkg::ST_SIGN;
          else                      state_nxt = itoa_pkg::ST_DIV;
        end
      end
      itoa_pkg::ST_SIGN: begin
        if (sts.slot_free) state_nxt = itoa_pkg::ST_DIV;
      end
      itoa_pkg::ST_DIV: begin
        if (!sts.ge && sts.emit_need) state_nxt = itoa_pkg::ST_PUT;
      end
      itoa_pkg::ST_PUT: begin
        if (sts.slot_free) state_nxt = sts.k_last ? itoa_pkg::ST_IDLE : itoa_pkg::ST_DIV;
      end
      itoa_pkg::ST_HEX: begin
        if (sts.slot_free && sts.hex_last) state_nxt = itoa_pkg::ST_IDLE;
      end
      default: state_nxt = itoa_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      itoa_pkg::ST_IDLE: cmd.load = accept;
      itoa_pkg::ST_SIGN: cmd.push_sign = sts.slot_free;
      itoa_pkg::ST_DIV: begin
        cmd.sub     = sts.ge;
        cmd.advance = !sts.ge && !sts.emit_need;
      end
      itoa_pkg::ST_PUT: cmd.push_digit = sts.slot_free;
      itoa_pkg::ST_HEX: cmd.push_hex = sts.slot_free;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= itoa_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ rtl/integer_to_ascii_formatter.sv @@
// one number per input transfer, one character per output transfer, last character flagged
// hex16: four characters, most significant nibble first, one per cycle unless the output stalls
// decimal: each digit counted by repeated subtraction of its power of ten, leading zeros skipped, sign first
// the input stalls while a number is being formatted and opens once the last character registers
// synchronous active-low reset clears the controller state and the output valid
module integer_to_ascii_formatter (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  itoa_pkg::in_item_t   in_payload,
  output logic                 out_valid,
  input  logic                 out_stall,
  output itoa_pkg::out_item_t  out_payload
);

  itoa_pkg::cmd_t cmd;
  itoa_pkg::sts_t sts;

  itoa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  itoa_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_payload  (in_payload),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .out_payload (out_payload),
    .cmd         (cmd),
    .sts         (sts)
  );

endmodule

@@ rtl/itoa_checker.sv @@
`include "integer_to_ascii_formatter_assert.svh"

module itoa_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input itoa_pkg::in_item_t  in_payload,
  input logic                out_valid,
  input logic                out_stall,
  input itoa_pkg::out_item_t out_payload
);

  logic in_xfer;
  logic fmt_known;
  logic out_held;
  logic ch_digit;
  logic ch_hex;
  logic ch_legal;

  assign in_xfer   = in_valid && !in_stall;
  assign fmt_known = in_payload.op <= itoa_pkg::OP_HEX16;
  assign out_held  = out_valid && out_stall;
  assign ch_digit  = (out_payload.ch >= itoa_pkg::CH_ZERO) &&
                     (out_payload.ch <= itoa_pkg::CH_ZERO + 7'd9);
  assign ch_hex    = (out_payload.ch >= itoa_pkg::CH_A) &&
                     (out_payload.ch <= itoa_pkg::CH_A + 7'd5);
  assign ch_legal  = (out_payload.ch == itoa_pkg::CH_MINUS) || ch_digit || ch_hex;

  `ITOA_ASSERT_RST(a_reset_clears_out, !rst_n |=> !out_valid, "output valid after reset")
  `ITOA_ASSERT(a_out_hold, out_held |=> out_valid && $stable(out_payload), "stalled output changed")
  `ITOA_ASSERT(a_busy_after_accept, in_xfer && fmt_known |=> in_stall, "not busy after transfer")
  `ITOA_ASSERT(a_busy_mid_number, out_valid && !out_payload.last |-> in_stall, "input open mid number")
  `ITOA_ASSERT(a_char_legal, out_valid |-> ch_legal, "illegal character")

endmodule

bind integer_to_ascii_formatter itoa_checker u_itoa_checker (.*);

@@ verif/tb_integer_to_ascii_formatter.sv @@
`timescale 1ns / 100ps

module tb_integer_to_ascii_formatter;

  localparam logic [2:0] OP_RSV5 = 3'd5;
  localparam logic [2:0] OP_RSV6 = 3'd6;
  localparam logic [2:0] OP_RSV7 = 3'd7;

  localparam logic [6:0] ASCII_ZERO  = 7'h30;
  localparam logic [6:0] ASCII_MINUS = 7'h2D;
  localparam logic [6:0] ASCII_A     = 7'h41;

  localparam int DRAIN_CYCLES = 150;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  itoa_pkg::in_item_t  in_payload;
  logic                out_valid;
  logic                out_stall;
  itoa_pkg::out_item_t out_payload;

  itoa_pkg::out_item_t expected_chars[$];
  itoa_pkg::out_item_t next_char;
  int          send_idle_pct;
  int          recv_stall_pct;
  int          numbers_sent;
  int          unused_sent;
  int          chars_checked;
  int          error_count;

  integer_to_ascii_formatter i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_payload  (in_payload),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_payload (out_payload)
  );

  always #1 clk = ~clk;

  initial begin
    #4_000_000;
    $display("tb_integer_to_ascii_formatter NOT OK");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= 40) begin
      $display("%0t mismatch: %s", $realtime, msg);
    end
  endtask

  // characters that one number should produce, in order
  function automatic void predict_chars(input logic [2:0] op, input logic [31:0] value);
    logic [6:0]  chars[$];
    logic [31:0] mag;
    logic [31:0] place;
    logic [31:0] digit;
    logic [15:0] neg16;
    logic [3:0]  nib;
    bit          is_decimal;
    bit          started;
    itoa_pkg::out_item_t item;
    mag = value;
    place = 32'd1_000_000_000;
    is_decimal = 1'b1;
    started = 1'b0;
    case (op)
      itoa_pkg::OP_S16: begin
        mag = {16'h0, value[15:0]};
        if (value[15]) begin
          chars.push_back(ASCII_MINUS);
          neg16 = 16'h0 - value[15:0];
          mag = {16'h0, neg16};
        end
        place = 32'd10_000;
      end
      itoa_pkg::OP_U16: begin
        mag = {16'h0, value[15:0]};
        place = 32'd10_000;
      end
      itoa_pkg::OP_S32: begin
        if (value[31]) begin
          chars.push_back(ASCII_MINUS);
          mag = 32'h0 - value;
        end
      end
      itoa_pkg::OP_U32: begin
        mag = value;
      end
      itoa_pkg::OP_HEX16: begin
        is_decimal = 1'b0;
        for (int s = 12; s >= 0; s -= 4) begin
          nib = value[s +: 4];
          if (nib < 4'd10) chars.push_back(ASCII_ZERO + 7'(nib));
          else chars.push_back(ASCII_A + 7'(nib) - 7'd10);
        end
      end
      default: begin
        is_decimal = 1'b0;
      end
    endcase
    if (is_decimal) begin
      if (mag == 32'd0) begin
        chars.push_back(ASCII_ZERO);
      end else begin
        while (place != 32'd0) begin
          digit = mag / place;
          mag = mag % place;
          if (digit != 32'd0) started = 1'b1;
          if (started) chars.push_back(ASCII_ZERO + digit[6:0]);
          place = place / 32'd10;
        end
      end
    end
    foreach (chars[i]) begin
      item.ch = chars[i];
      item.last = (i == chars.size() - 1);
      expected_chars.push_back(item);
    end
  endfunction

  // called at a clock edge; leaves in_valid high after the transfer
  task automatic send_number(input logic [2:0] op, input logic [31:0] value);
    itoa_pkg::in_item_t item;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    item.op = op;
    item.value = value;
    in_valid <= 1'b1;
    in_payload <= item;
    do @(posedge clk); while (in_stall);
    predict_chars(op, value);
    numbers_sent++;
    if (op > itoa_pkg::OP_HEX16) unused_sent++;
  endtask

  task automatic wait_all_chars();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_chars.size() != 0);
  endtask

  function automatic logic [31:0] pick_value();
    logic [31:0] p;
    int          k;
    case ($urandom_range(5))
      0: pick_value = $urandom;
      1: pick_value = $urandom_range(99);
      2: begin
        k = $urandom_range(9);
        p = 32'd1;
        repeat (k) p = p * 32'd10;
        p = p - $urandom_range(1);
        pick_value = $urandom_range(1) ? (32'h0 - p) : p;
      end
      3: pick_value = 32'h0 - $urandom_range(1, 99);
      4: begin
        k = $urandom_range(4);
        p = 32'd1;
        repeat (k) p = p * 32'd10;
        pick_value = {16'($urandom), 16'(p - $urandom_range(1))};
      end
      default: pick_value = {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
    endcase
  endfunction

  task automatic test_extremes();
    send_number(itoa_pkg::OP_S16, 32'h0000_0000);
    send_number(itoa_pkg::OP_S16, 32'h0000_7FFF);
    send_number(itoa_pkg::OP_S16, 32'h0000_8000);
    send_number(itoa_pkg::OP_S16, 32'hFFFF_FFFF);
    send_number(itoa_pkg::OP_S16, 32'h1234_0001);
    send_number(itoa_pkg::OP_U16, 32'h0000_0000);
    send_number(itoa_pkg::OP_U16, 32'hFFFF_FFFF);
    send_number(itoa_pkg::OP_U16, 32'hABCD_0000);
    send_number(itoa_pkg::OP_U16, 32'h0000_2710);
    send_number(itoa_pkg::OP_S32, 32'h0000_0000);
    send_number(itoa_pkg::OP_S32, 32'h7FFF_FFFF);
    send_number(itoa_pkg::OP_S32, 32'h8000_0000);
    send_number(itoa_pkg::OP_S32, 32'hFFFF_FFFF);
    send_number(itoa_pkg::OP_U32, 32'h0000_0000);
    send_number(itoa_pkg::OP_U32, 32'hFFFF_FFFF);
    send_number(itoa_pkg::OP_U32, 32'd1_000_000_000);
    send_number(itoa_pkg::OP_HEX16, 32'h0000_0000);
    send_number(itoa_pkg::OP_HEX16, 32'h0000_FFFF);
    send_number(itoa_pkg::OP_HEX16, 32'h1234_5A9F);
    send_number(itoa_pkg::OP_HEX16, 32'hFFFF_0C3E);
  endtask

  task automatic test_unused_formats();
    send_number(OP_RSV5, 32'hFFFF_FFFF);
    send_number(OP_RSV6, 32'h0000_0000);
    send_number(OP_RSV7, 32'h8000_0001);
    send_number(itoa_pkg::OP_U32, 32'd42);
  endtask

  task automatic test_random_mix(input int idle_pct, input int stall_pct, input int count);
    int done;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    done = 0;
    while (done < count) begin
      if ($urandom_range(15) == 0) begin
        send_number(3'($urandom_range(OP_RSV5, OP_RSV7)), $urandom);
      end else begin
        send_number(3'($urandom_range(itoa_pkg::OP_S16, itoa_pkg::OP_HEX16)), pick_value());
        done++;
      end
    end
  endtask

  // the input side stops until every character is out, then restarts
  task automatic test_drain_pause();
    repeat (8) send_number(3'($urandom_range(itoa_pkg::OP_S16, itoa_pkg::OP_HEX16)),
                           pick_value());
    wait_all_chars();
    repeat (8) send_number(3'($urandom_range(itoa_pkg::OP_S16, itoa_pkg::OP_HEX16)),
                           pick_value());
  endtask

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected char %h last %b",
                                  out_payload.ch, out_payload.last));
      end else begin
        next_char = expected_chars.pop_front();
        if (out_payload.ch !== next_char.ch) begin
          report_mismatch($sformatf("ch %h, want %h", out_payload.ch, next_char.ch));
        end
        if (out_payload.last !== next_char.last) begin
          report_mismatch($sformatf("last %b, want %b on ch %h",
                                    out_payload.last, next_char.last, next_char.ch));
        end
        chars_checked++;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_payload = '0;
    send_idle_pct = 21;
    recv_stall_pct = 88;
    numbers_sent = 0;
    unused_sent = 0;
    chars_checked = 0;
    error_count = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_extremes();
    test_unused_formats();
    test_random_mix(21, 88, 110);
    test_random_mix(88, 21, 110);
    test_drain_pause();
    test_random_mix(0, 0, 110);

    wait_all_chars();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d numbers sent (%0d with unused format codes), %0d characters checked",
             numbers_sent, unused_sent, chars_checked);
    $display("all five formats and their extremes, under heavy and light idling on both sides");
    if (error_count == 0) begin
      $display("tb_integer_to_ascii_formatter OK");
    end else begin
      $display("tb_integer_to_ascii_formatter NOT OK");
    end
    $finish;
  end

endmodule
